/* sv/fgsd_pkg.sv */
// Package: shared constants, types and the scale decode for the FP8 dequantizer.
`timescale 1ns / 1ps
package fgsd_pkg;
   localparam int CODE_W  = 8;
   localparam int SCALE_W = 32;
   localparam int VALUE_W = 16;
   localparam int MF_W    = 24;
   localparam int PROD_W  = 28;
   localparam logic [VALUE_W-1:0] BF16_QNAN = 16'h7FC0;
   localparam logic [VALUE_W-1:0] BF16_INF  = 16'h7F80;

   // decoded scale, shared by all lanes
   typedef struct packed {
      logic              sign;
      logic              is_nan;
      logic              is_inf;
      logic              is_zero;
      logic [MF_W-1:0]   mant;
      logic [7:0]        exp_eff;
   } scale_type;

   function automatic scale_type decode_scale(input logic [SCALE_W-1:0] s);
      scale_type r;
      r.sign    = s[31];
      r.is_nan  = (s[30:23] == 8'hFF) && (s[22:0] != 23'd0);
      r.is_inf  = (s[30:23] == 8'hFF) && (s[22:0] == 23'd0);
      r.is_zero = (s[30:0] == 31'd0);
      r.mant    = {(s[30:23] != 8'd0), s[22:0]};
      r.exp_eff = (s[30:23] == 8'd0) ? 8'd1 : s[30:23];
      return r;
   endfunction
endpackage

/* sv/fgsd_lane.sv */
// One lane: FP8 decode, product with the scale, FP32 then BF16 rounding; two stages.
`timescale 1ns / 1ps
module fgsd_lane (
   input  logic                          clock,
   input  logic                          adv_0,
   input  logic                          adv_1,
   input  logic [fgsd_pkg::CODE_W-1:0]   code,
   input  fgsd_pkg::scale_type           scale,
   output logic [fgsd_pkg::VALUE_W-1:0]  value
);
   localparam logic [1:0] SPEC_NORMAL = 2'd0;
   localparam logic [1:0] SPEC_NAN    = 2'd1;
   localparam logic [1:0] SPEC_INF    = 2'd2;
   localparam logic [1:0] SPEC_ZERO   = 2'd3;

   logic [fgsd_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [9:0]           exp_ff, exp_in;
   logic                        sign_ff, sign_in;
   logic [1:0]                  spec_ff, spec_in;
   logic [fgsd_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [3:0]                  m8;
   logic [3:0]                  e8;

   always_comb begin
      e8      = (code[6:3] == 4'd0) ? 4'd1 : code[6:3];
      m8      = {(code[6:3] != 4'd0), code[2:0]};
      sign_in = code[7] ^ scale.sign;
      prod_in = m8 * scale.mant;
      exp_in  = 10'(signed'({6'd0, e8})) + 10'(signed'({2'd0, scale.exp_eff})) - 10'sd160;
      if ((code[6:0] == 7'h7F) || scale.is_nan || (scale.is_inf && m8 == 4'd0))
         spec_in = SPEC_NAN;
      else if (scale.is_inf)
         spec_in = SPEC_INF;
      else if (m8 == 4'd0 || scale.is_zero)
         spec_in = SPEC_ZERO;
      else
         spec_in = SPEC_NORMAL;
   end

   always_ff @(posedge clock) begin
      if (adv_0) begin
         prod_ff <= prod_in;
         exp_ff  <= exp_in;
         sign_ff <= sign_in;
         spec_ff <= spec_in;
      end
      if (adv_1)
         value_ff <= value_in;
   end

   logic [4:0]          n;
   logic signed [10:0]  sh, sh2;
   logic [55:0]         wide;
   logic [27:0]         q;
   logic [27:0]         rem, half;
   logic [5:0]          shu;
   logic [31:0]         mag;
   logic [32:0]         rnd;
   logic [11:0]         ebits;

   always_comb begin
      n = 5'd0;
      for (int i = 0; i < fgsd_pkg::PROD_W; i++)
         if (prod_ff[i]) n = 5'(i);
      sh  = 11'(signed'({6'd0, n})) - 11'sd23;
      sh2 = -11'sd149 - 11'(exp_ff);
      if (sh2 > sh) sh = sh2;
      q = '0; rem = '0; half = '0; shu = '0; wide = '0;
      if (sh <= 0) begin
         shu  = 6'(-sh);
         wide = {28'd0, prod_ff} << shu;
         q    = wide[27:0];
      end else begin
         shu  = (sh > 11'sd28) ? 6'd28 : 6'(sh);
         wide = {prod_ff, 28'd0} >> shu;
         q    = wide[55:28];
         rem  = wide[27:0];
         half = 28'h8000000;
         if (rem > half || (rem == half && q[0]))
            q = q + 28'd1;
      end
      ebits = 12'(exp_ff) + 12'(sh) + 12'd149;
      mag   = {ebits[8:0], 23'd0} + {4'd0, q};
      if (q == 28'd0) mag = '0;
      if (ebits[11] == 1'b0 && ebits[10:9] != 2'd0) mag = 32'h7F800000;
      if (mag >= 32'h7F800000) mag = 32'h7F800000;
      rnd = {1'b0, mag} + 33'h7FFF + {32'd0, mag[16]};
      unique case (spec_ff)
         SPEC_NAN:  value_in = fgsd_pkg::BF16_QNAN;
         SPEC_INF:  value_in = {sign_ff, fgsd_pkg::BF16_INF[14:0]};
         SPEC_ZERO: value_in = {sign_ff, 15'd0};
         default:   value_in = {sign_ff, rnd[30:16]};
      endcase
   end

   assign value = value_ff;
endmodule

/* sv/fp8_group_scale_dequant_bf16.sv */
// Top level: eight-lane FP8 E4M3FN group dequantizer with BF16 results.
//
// Takes one transfer per cycle while req_tready is high. Each lane decodes its
// code, multiplies the 4-bit significand by the 24-bit scale significand in the
// first stage, and rounds to FP32 then BF16 in the second register stage.
// While the output is held the first stage still takes a transfer into an empty
// slot; once both stages are full, req_tready falls.
`timescale 1ns / 1ps
module fp8_group_scale_dequant_bf16 #(
   parameter int LANES = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // code lane 0 .. LANES-1, then group_scale
   input  logic [LANES*8+31:0]           req_tdata,
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // value lane 0 .. LANES-1
   output logic [LANES*16-1:0]           rsp_tdata,
   output logic                          rsp_tlast
);
   logic v0_ff, v0_in, v1_ff, v1_in, l0_ff, l1_ff;
   logic adv_0, adv_1;
   fgsd_pkg::scale_type scale;

   assign adv_1      = v0_ff && (!v1_ff || rsp_tready);
   assign adv_0      = req_tvalid && req_tready;
   assign req_tready = !v0_ff || adv_1;
   assign v0_in      = adv_0 ? 1'b1 : (adv_1 ? 1'b0 : v0_ff);
   assign v1_in      = adv_1 ? 1'b1 : ((rsp_tready) ? 1'b0 : v1_ff);
   assign scale      = fgsd_pkg::decode_scale(req_tdata[LANES*8 +: 32]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
      end
      if (adv_0) l0_ff <= req_tlast;
      if (adv_1) l1_ff <= l0_ff;
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      fgsd_lane u_lane (
         .clock (clock),
         .adv_0 (adv_0),
         .adv_1 (adv_1),
         .code  (req_tdata[g*8 +: 8]),
         .scale (scale),
         .value (rsp_tdata[g*16 +: 16])
      );
   end

   assign rsp_tvalid = v1_ff;
   assign rsp_tlast  = l1_ff;
endmodule

/* sv/fgsd_check.sv */
// Checker: port-level properties of the dequantizer, bound to the top level.
`timescale 1ns / 1ps
module fgsd_check (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic rsp_tlast
);
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tlast))
      else $error("rsp dropped under stall");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("result missing");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("stall without back pressure");
endmodule

bind fp8_group_scale_dequant_bf16 fgsd_check u_check (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tlast(rsp_tlast)
);

/* sim/tb_top.sv */
// Testbench for the FP8 E4M3FN group dequantizer: directed and random transfers.
`timescale 1ns / 1ps
module tb_top;
   localparam int LANES = 8;

   typedef struct packed {
      logic [LANES*16-1:0] values;
      logic                last;
   } bf16_row_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [LANES*8+31:0] req_tdata;
   logic req_tlast;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [LANES*16-1:0] rsp_tdata;
   logic rsp_tlast;

   bf16_row_type expected_rows[$];
   int error_count;
   int row_count;
   int results_seen;
   bit sink_stall_off;

   fp8_group_scale_dequant_bf16 #(.LANES(LANES)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one lane: exact fp8 * fp32, round to fp32 then to bf16
   function automatic logic [15:0] scaled_bf16(input logic [7:0] code,
                                               input logic [31:0] scale);
      logic        sgn;
      logic [3:0]  e8;
      logic [2:0]  m8;
      logic [7:0]  ef;
      logic [22:0] mf;
      logic [63:0] sig8, sigf, prod, q, mag, rem, half;
      int          ex, msb, sh, sh2;
      sgn = code[7] ^ scale[31];
      e8 = code[6:3];
      m8 = code[2:0];
      ef = scale[30:23];
      mf = scale[22:0];
      if (e8 == 4'hF && m8 == 3'h7) return 16'h7FC0;
      if (ef == 8'hFF && mf != 0) return 16'h7FC0;
      sig8 = (e8 != 0) ? 64'(8 + m8) : 64'(m8);
      if (ef == 8'hFF) return (sig8 == 0) ? 16'h7FC0 : {sgn, 15'h7F80};
      sigf = (ef != 0) ? 64'({1'b1, mf}) : 64'(mf);
      if (sig8 == 0 || sigf == 0) return {sgn, 15'd0};
      prod = sig8 * sigf;
      ex = ((e8 != 0 ? int'(e8) : 1) - 10) + ((ef != 0 ? int'(ef) : 1) - 150);
      msb = 0;
      while (msb < 63 && (prod >> (msb + 1)) != 0) msb++;
      sh = msb - 23;
      sh2 = -149 - ex;
      if (sh2 > sh) sh = sh2;
      if (sh <= 0) begin
         q = prod << (-sh);
      end else begin
         rem = prod & ((64'd1 << sh) - 1);
         half = 64'd1 << (sh - 1);
         q = prod >> sh;
         if (rem > half || (rem == half && q[0])) q++;
      end
      mag = (64'(ex + sh + 149) << 23) + q;
      if (q == 0) mag = 0;
      if (mag >= 64'h7F800000) mag = 64'h7F800000;
      mag = (mag + 64'h7FFF + ((mag >> 16) & 1)) >> 16;
      return {sgn, mag[14:0]};
   endfunction

   task automatic send_row(input logic [7:0] codes[LANES], input logic [31:0] scale,
                           input logic last);
      bf16_row_type row;
      int gap;
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      for (int i = 0; i < LANES; i++) begin
         req_tdata[i*8 +: 8] <= codes[i];
         row.values[i*16 +: 16] = scaled_bf16(codes[i], scale);
      end
      row.last = last;
      req_tdata[LANES*8 +: 32] <= scale;
      req_tlast <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_rows.push_back(row);
      row_count++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_scale();
      logic [31:0] s;
      case ($urandom_range(0, 9))
         0: s = {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};
         1: s = {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
         2: s = {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
         3: s = {$urandom_range(0, 1) == 1, 8'($urandom_range(0, 12)), 23'($urandom)};
         4: s = {$urandom_range(0, 1) == 1, 8'($urandom_range(236, 254)), 23'($urandom)};
         5: s = {$urandom_range(0, 1) == 1, 31'd0};
         default: s = $urandom;
      endcase
      return s;
   endfunction

   task automatic test_directed();
      logic [7:0] codes[LANES];
      logic [31:0] scales[12];
      logic [7:0] special[8];
      special = '{8'h00, 8'h80, 8'h7F, 8'hFF, 8'h01, 8'h7E, 8'hFE, 8'h08};
      scales = '{32'h3F800000, 32'hBF800000, 32'h00000000, 32'h80000000,
                 32'h7F800000, 32'hFF800000, 32'h7FC00001, 32'h00000001,
                 32'h7F7FFFFF, 32'h007FFFFF, 32'h3F80FFFF, 32'hFFFFFFFF};
      foreach (scales[k]) begin
         for (int i = 0; i < LANES; i++) codes[i] = special[(i + k) % 8];
         send_row(codes, scales[k], k[0]);
      end
      // all 256 codes once at unit scale
      for (int j = 0; j < 32; j++) begin
         for (int i = 0; i < LANES; i++) codes[i] = 8'(j * 8 + i);
         send_row(codes, 32'h3F800000, 1'b0);
      end
   endtask

   task automatic test_random(input int count);
      logic [7:0] codes[LANES];
      for (int n = 0; n < count; n++) begin
         for (int i = 0; i < LANES; i++) codes[i] = 8'($urandom);
         sink_stall_off = (n / 100) % 3 == 2;
         send_row(codes, random_scale(), 1'($urandom));
      end
   endtask

   task automatic test_all_codes();
      logic [7:0] codes[LANES];
      for (int j = 0; j < 32; j++) begin
         for (int i = 0; i < LANES; i++) codes[i] = 8'(j * 8 + i);
         send_row(codes, random_scale(), 1'($urandom));
      end
   endtask

   // result sink with random stalls
   initial begin
      int idle;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         idle = sink_stall_off ? 0 : $urandom_range(0, 5);
         if (idle != 0) begin
            rsp_tready <= 1'b0;
            repeat (idle) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      bf16_row_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_rows.size() == 0) begin
            $display("%0t: unexpected transfer data=%h last=%b", $time, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = expected_rows.pop_front();
            for (int i = 0; i < LANES; i++)
               if (rsp_tdata[i*16 +: 16] !== want.values[i*16 +: 16]) begin
                  $display("%0t: lane %0d expected %h actual %h", $time, i,
                           want.values[i*16 +: 16], rsp_tdata[i*16 +: 16]);
                  error_count++;
               end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      int drain;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      error_count = 0;
      row_count = 0;
      results_seen = 0;
      sink_stall_off = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_all_codes();
      test_random(870);
      req_tvalid <= 1'b0;
      drain = 0;
      while (expected_rows.size() != 0 && drain < 10000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      $display("covered %0d transfers, %0d results: special codes, inf/nan/zero/subnormal",
               row_count, results_seen);
      $display("scales, every code at unit and random scale, random stalls on both sides");
      if (error_count == 0 && expected_rows.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end
endmodule

/* fp8_group_scale_dequant_bf16.f */
sv/fgsd_pkg.sv
sv/fgsd_lane.sv
sv/fp8_group_scale_dequant_bf16.sv
sv/fgsd_check.sv
sim/tb_top.sv
